// File: hw/rtl/baro_sensor_compensation_macros.svh
// Assertion macros for the compensation block's checker.
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

// Checked on every rising edge outside reset.
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bsc_pkg.sv
// Shared widths, register codes and oversampling tables of the compensation block.
`default_nettype none

package bsc_pkg;

  localparam int RAW_W       = 24;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int OSR_W       = 3;
  localparam int CAL_HIGH_W  = 16;
  localparam int OUT_W       = 32;

  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam int WORK_FRAC         = 16;

  // Coefficient widths: c0/c1, c00/c10, and the 16-bit words.
  localparam int COEF_S_W = 12;
  localparam int COEF_M_W = 20;
  localparam int COEF_W_W = 16;

  // Scale factor k = odd * 2^shift, odd = 2^(index+1) - 1.
  localparam int SHIFT_COARSE = 19;
  localparam int SHIFT_FINE   = 13;
  localparam int ODD_W        = 8;
  localparam int RECIP_W      = 32;
  localparam int DIV_W        = 27;

  // Datapath widths, Q.16 throughout.
  localparam int PSC_W    = 24;
  localparam int INNER1_W = 40;
  localparam int INNER2_W = 45;
  localparam int TERM_W   = 50;
  localparam int PQ_W     = 51;
  localparam int TQ_W     = 38;
  localparam int LO1_W    = 20;
  localparam int LO2_W    = 22;

  localparam logic [CFG_INDEX_W-1:0] REG_CALIB_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CALIB_MID  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CALIB_HIGH = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_P_OSR      = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_T_OSR      = CFG_INDEX_W'(4);

  localparam logic [OSR_W-1:0] OSR_RESET = OSR_W'(1);

  // Odd part of the scale factor.
  function automatic logic [ODD_W-1:0] osr_odd(input logic [OSR_W-1:0] idx);
    logic [ODD_W-1:0] r;
    unique case (idx)
      3'd0: r = 8'd1;
      3'd1: r = 8'd3;
      3'd2: r = 8'd7;
      3'd3: r = 8'd15;
      3'd4: r = 8'd31;
      3'd5: r = 8'd63;
      3'd6: r = 8'd127;
      3'd7: r = 8'd255;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

  // floor((2^32 - 1) / odd): the quotient estimate is at most one low.
  function automatic logic [RECIP_W-1:0] osr_recip(input logic [OSR_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    unique case (idx)
      3'd0: r = 32'hFFFF_FFFF;
      3'd1: r = 32'h5555_5555;
      3'd2: r = 32'h2492_4924;
      3'd3: r = 32'h1111_1111;
      3'd4: r = 32'h0842_1084;
      3'd5: r = 32'h0410_4104;
      3'd6: r = 32'h0204_0810;
      3'd7: r = 32'h0101_0101;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/baro_sensor_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
//
// Sample channel: pressure_raw and temperature_raw (24-bit two's complement as
// read from the sensor) are taken at an edge where sample_valid is high and
// sample_stall is low. Result channel: pressure_comp and temperature_comp are
// signed fixed point with OUT_FRAC_BITS fraction bits (Q24.8 by default),
// saturated to 32 bits; saturated flags a clip of either one. The result is
// taken at an edge where result_valid is high and result_stall is low.
// Config channel: cfg_ready is always high; cfg_index selects calib low, mid,
// high, pressure OSR index or temperature OSR index; indexes 5 to 7 are dropped.
// Write config only while no item is in flight.
// Pipeline: the accepting edge loads stage 1; 4 scaler stages, a product stage,
// two 3-stage multiply-add units in series, sum and round make 13 stages, then
// the clipping output register drives result_valid. Throughput: one item per
// cycle while not stalled; every stage takes a new item in every unstalled cycle.
// Each multiply-add splits its wide operand into two partial products.
// Reset: synchronous; clears the pipeline valids and loads the register reset
// values (calibration zero, both OSR indexes 1). There is no clearing pass.
// Stall: a held result stops the pipeline only when the stage in front of the
// output holds an item; while that stage is empty the pipeline keeps moving, so
// sample_stall is high only while result_valid and result_stall are both high.
`default_nettype none

module baro_sensor_compensation #(
  parameter int OUT_FRAC_BITS = bsc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic [bsc_pkg::RAW_W-1:0]               pressure_raw,
  input  logic [bsc_pkg::RAW_W-1:0]               temperature_raw,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic signed [bsc_pkg::OUT_W-1:0]        pressure_comp,
  output logic signed [bsc_pkg::OUT_W-1:0]        temperature_comp,
  output logic                                    saturated,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [bsc_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]          cfg_data
);

  localparam int PSC_W    = bsc_pkg::PSC_W;
  localparam int INNER1_W = bsc_pkg::INNER1_W;
  localparam int INNER2_W = bsc_pkg::INNER2_W;
  localparam int TERM_W   = bsc_pkg::TERM_W;
  localparam int PQ_W     = bsc_pkg::PQ_W;
  localparam int TQ_W     = bsc_pkg::TQ_W;
  localparam int OUT_W    = bsc_pkg::OUT_W;
  localparam int FRAC     = bsc_pkg::WORK_FRAC;
  localparam int CW_S     = bsc_pkg::COEF_S_W;
  localparam int CW_M     = bsc_pkg::COEF_M_W;
  localparam int CW_W     = bsc_pkg::COEF_W_W;
  localparam int CM_Q_W   = CW_M + FRAC;
  localparam int VLD_LAST = 13;

  // final Q.16 -> Q.OUT_FRAC_BITS shift with round half up
  localparam int RSH = FRAC - OUT_FRAC_BITS;
  localparam logic signed [PQ_W-1:0] P_RND = PQ_W'((1 << RSH) >> 1);
  localparam logic signed [TQ_W-1:0] T_RND = TQ_W'((1 << RSH) >> 1);
  localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));
  localparam logic signed [PQ_W-1:0] P_MAX = PQ_W'(OUT_MAX);
  localparam logic signed [PQ_W-1:0] P_MIN = PQ_W'(OUT_MIN);
  localparam logic signed [TQ_W-1:0] T_MAX = TQ_W'(OUT_MAX);
  localparam logic signed [TQ_W-1:0] T_MIN = TQ_W'(OUT_MIN);

  // ---------------------------------------------------------------- config
  logic [bsc_pkg::CFG_DATA_W-1:0]  calib_low;
  logic [bsc_pkg::CFG_DATA_W-1:0]  calib_mid;
  logic [bsc_pkg::CAL_HIGH_W-1:0]  calib_high;
  logic [bsc_pkg::OSR_W-1:0]       p_osr;
  logic [bsc_pkg::OSR_W-1:0]       t_osr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_low  <= '0;
      calib_mid  <= '0;
      calib_high <= '0;
      p_osr      <= bsc_pkg::OSR_RESET;
      t_osr      <= bsc_pkg::OSR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsc_pkg::REG_CALIB_LOW:  calib_low  <= cfg_data;
        bsc_pkg::REG_CALIB_MID:  calib_mid  <= cfg_data;
        bsc_pkg::REG_CALIB_HIGH: calib_high <= cfg_data[bsc_pkg::CAL_HIGH_W-1:0];
        bsc_pkg::REG_P_OSR:      p_osr      <= cfg_data[bsc_pkg::OSR_W-1:0];
        bsc_pkg::REG_T_OSR:      t_osr      <= cfg_data[bsc_pkg::OSR_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpack; byte 0 sits in the top bits of calib_low.
  logic signed [CW_S-1:0] c0, c1;
  logic signed [CW_M-1:0] c00, c10;
  logic signed [CW_W-1:0] c01, c11, c20, c21, c30;
  logic signed [CM_Q_W-1:0] c00_q, c10_q;

  assign c0    = $signed(calib_low[63:52]);
  assign c1    = $signed(calib_low[51:40]);
  assign c00   = $signed(calib_low[39:20]);
  assign c10   = $signed(calib_low[19:0]);
  assign c01   = $signed(calib_mid[63:48]);
  assign c11   = $signed(calib_mid[47:32]);
  assign c20   = $signed(calib_mid[31:16]);
  assign c21   = $signed(calib_mid[15:0]);
  assign c30   = $signed(calib_high);
  assign c00_q = CM_Q_W'(c00) <<< FRAC;
  assign c10_q = CM_Q_W'(c10) <<< FRAC;

  // ------------------------------------------------------------ flow control
  // advance moves stages 1..13; the output register moves when not held.
  logic            out_hold;
  logic            advance;
  logic [VLD_LAST:1] vld;

  assign out_hold     = result_valid && result_stall;
  assign advance      = !out_hold || !vld[VLD_LAST];
  assign sample_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        vld <= {vld[VLD_LAST-1:1], sample_valid};
      end
      if (!out_hold) begin
        result_valid <= vld[VLD_LAST];
      end
    end
  end

  // -------------------------------------------------------- stages 1 to 4
  logic signed [PSC_W-1:0] psc4, tsc4;

  bsc_scale u_scale_p (
    .clk       (clk),
    .en        (advance),
    .raw       (pressure_raw),
    .osr_index (p_osr),
    .scaled    (psc4)
  );

  bsc_scale u_scale_t (
    .clk       (clk),
    .en        (advance),
    .raw       (temperature_raw),
    .osr_index (t_osr),
    .scaled    (tsc4)
  );

  // -------------------------------------------------------------- stage 5
  // inner1 = c20 + P*c30, cross = c11 + P*c21, tp = T*c01, tq = c0/2 + c1*T
  logic signed [PSC_W+CW_W-1:0] p_c30, p_c21, t_c01;
  logic signed [PSC_W+CW_S-1:0] t_c1;
  logic signed [INNER1_W-1:0]   inner1_c, cross_c;
  logic signed [TQ_W-1:0]       tq_c;

  always_comb begin
    p_c30    = psc4 * c30;
    p_c21    = psc4 * c21;
    t_c01    = tsc4 * c01;
    t_c1     = tsc4 * c1;
    inner1_c = (INNER1_W'(c20) <<< FRAC) + INNER1_W'(p_c30);
    cross_c  = (INNER1_W'(c11) <<< FRAC) + INNER1_W'(p_c21);
    tq_c     = (TQ_W'(c0) <<< (FRAC - 1)) + TQ_W'(t_c1);
  end

  logic signed [PSC_W-1:0]    psc5, tsc5;
  logic signed [INNER1_W-1:0] inner1_5, cross5;
  logic signed [TERM_W-1:0]   tp5;
  logic signed [TQ_W-1:0]     tq5;

  // delay lines alongside the multiply-add units
  logic signed [PSC_W-1:0]  psc_d [3];
  logic signed [PSC_W-1:0]  tsc_d [3];
  logic signed [TERM_W-1:0] tp_d  [3];
  logic signed [TQ_W-1:0]   tq_d  [7];

  // ------------------------------------------------------------ stages 6-8
  logic signed [INNER2_W-1:0] inner2_8;
  logic signed [INNER2_W-1:0] pcross_8;

  // inner2 = c10 + P*inner1
  bsc_qmul #(
    .A_W   (PSC_W),
    .B_W   (INNER1_W),
    .LO_W  (bsc_pkg::LO1_W),
    .ADD_W (CM_Q_W),
    .OUT_W (INNER2_W)
  ) u_qmul_inner2 (
    .clk    (clk),
    .en     (advance),
    .a      (psc5),
    .b      (inner1_5),
    .addend (c10_q),
    .result (inner2_8)
  );

  // P*(c11 + P*c21)
  bsc_qmul #(
    .A_W   (PSC_W),
    .B_W   (INNER1_W),
    .LO_W  (bsc_pkg::LO1_W),
    .ADD_W (1),
    .OUT_W (INNER2_W)
  ) u_qmul_cross (
    .clk    (clk),
    .en     (advance),
    .a      (psc5),
    .b      (cross5),
    .addend (1'sb0),
    .result (pcross_8)
  );

  // ----------------------------------------------------------- stages 9-11
  logic signed [TERM_W-1:0] pq0_11, tterm_11;

  // c00 + P*inner2
  bsc_qmul #(
    .A_W   (PSC_W),
    .B_W   (INNER2_W),
    .LO_W  (bsc_pkg::LO2_W),
    .ADD_W (CM_Q_W),
    .OUT_W (TERM_W)
  ) u_qmul_poly (
    .clk    (clk),
    .en     (advance),
    .a      (psc_d[2]),
    .b      (inner2_8),
    .addend (c00_q),
    .result (pq0_11)
  );

  // T*c01 + T*P*(c11 + P*c21)
  bsc_qmul #(
    .A_W   (PSC_W),
    .B_W   (INNER2_W),
    .LO_W  (bsc_pkg::LO2_W),
    .ADD_W (TERM_W),
    .OUT_W (TERM_W)
  ) u_qmul_temp (
    .clk    (clk),
    .en     (advance),
    .a      (tsc_d[2]),
    .b      (pcross_8),
    .addend (tp_d[2]),
    .result (tterm_11)
  );

  // -------------------------------------------------------- stages 12-13
  logic signed [PQ_W-1:0] pq12, pr13;
  logic signed [TQ_W-1:0] tr13;

  // ------------------------------------------------------ stage 14 (output)
  logic p_over, p_under, t_over, t_under;
  logic signed [OUT_W-1:0] p_clip, t_clip;

  always_comb begin
    p_over  = pr13 > P_MAX;
    p_under = pr13 < P_MIN;
    t_over  = tr13 > T_MAX;
    t_under = tr13 < T_MIN;
    p_clip  = p_over ? OUT_W'(P_MAX) : (p_under ? OUT_W'(P_MIN) : OUT_W'(pr13));
    t_clip  = t_over ? OUT_W'(T_MAX) : (t_under ? OUT_W'(T_MIN) : OUT_W'(tr13));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      psc5     <= psc4;
      tsc5     <= tsc4;
      inner1_5 <= inner1_c;
      cross5   <= cross_c;
      tp5      <= TERM_W'(t_c01);
      tq5      <= tq_c;

      psc_d[0] <= psc5;
      tsc_d[0] <= tsc5;
      tp_d[0]  <= tp5;
      for (int i = 1; i < 3; i++) begin
        psc_d[i] <= psc_d[i-1];
        tsc_d[i] <= tsc_d[i-1];
        tp_d[i]  <= tp_d[i-1];
      end
      tq_d[0] <= tq5;
      for (int i = 1; i < 7; i++) begin
        tq_d[i] <= tq_d[i-1];
      end

      pq12 <= PQ_W'(pq0_11) + PQ_W'(tterm_11);

      pr13 <= (pq12 + P_RND) >>> RSH;
      tr13 <= (tq_d[6] + T_RND) >>> RSH;
    end
    if (!out_hold) begin
      pressure_comp    <= p_clip;
      temperature_comp <= t_clip;
      saturated        <= p_over || p_under || t_over || t_under;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsc_scale.sv
// Four-stage scaler: round(raw * 2^16 / k) for the selected oversampling factor.
`default_nettype none

module bsc_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [bsc_pkg::RAW_W-1:0]         raw,
  input  logic [bsc_pkg::OSR_W-1:0]         osr_index,
  output logic signed [bsc_pkg::PSC_W-1:0]  scaled
);

  localparam int N_W    = bsc_pkg::RAW_W + bsc_pkg::WORK_FRAC + 1;
  localparam int D_W    = N_W - bsc_pkg::SHIFT_FINE;
  localparam int DIV_W  = bsc_pkg::DIV_W;
  localparam int PROD_W = DIV_W + bsc_pkg::RECIP_W;
  localparam int ODD_W  = bsc_pkg::ODD_W;

  // stage 1: add k/2, take the power-of-two part as a floor shift, fold the sign
  logic [ODD_W-1:0]       odd_in;
  logic signed [N_W-1:0]  half_k;
  logic signed [N_W-1:0]  num;
  logic signed [D_W-1:0]  quo_pow2;
  logic [D_W-1:0]         flipped;
  logic [DIV_W-1:0]       dividend;

  logic [DIV_W-1:0]             s1_dividend;
  logic                         s1_neg;
  logic [bsc_pkg::OSR_W-1:0]    s1_index;

  always_comb begin
    odd_in   = bsc_pkg::osr_odd(osr_index);
    half_k   = osr_index[2] ? (N_W'(odd_in) << (bsc_pkg::SHIFT_FINE - 1))
                            : (N_W'(odd_in) << (bsc_pkg::SHIFT_COARSE - 1));
    num      = $signed({raw[bsc_pkg::RAW_W-1], raw, {bsc_pkg::WORK_FRAC{1'b0}}}) + half_k;
    quo_pow2 = osr_index[2] ? D_W'(num >>> bsc_pkg::SHIFT_FINE)
                            : D_W'(num >>> bsc_pkg::SHIFT_COARSE);
    // floor(x/m) = -floor((-x + m - 1)/m) for negative x; ~x + m = -x + m - 1
    flipped  = D_W'(~quo_pow2) + D_W'(odd_in);
    dividend = quo_pow2[D_W-1] ? DIV_W'(flipped) : DIV_W'(quo_pow2);
  end

  // stage 2: reciprocal multiply
  logic [PROD_W-1:0]          prod;
  logic [DIV_W-1:0]           s2_quo;
  logic [DIV_W-1:0]           s2_dividend;
  logic                       s2_neg;
  logic [bsc_pkg::OSR_W-1:0]  s2_index;

  assign prod = s1_dividend * bsc_pkg::osr_recip(s1_index);

  // stage 3: remainder check
  logic [ODD_W-1:0]        odd3;
  logic [DIV_W+ODD_W-1:0]  back;
  logic [DIV_W:0]          rem;
  logic [DIV_W-1:0]        s3_quo;
  logic                    s3_bump;
  logic                    s3_neg;

  always_comb begin
    odd3 = bsc_pkg::osr_odd(s2_index);
    back = s2_quo * odd3;
    rem  = (DIV_W+1)'(s2_dividend) - (DIV_W+1)'(back);
  end

  // stage 4: correct and restore sign
  logic [DIV_W-1:0]          mag;
  logic [bsc_pkg::PSC_W-1:0] mag_lo;

  always_comb begin
    mag    = s3_quo + DIV_W'(s3_bump);
    mag_lo = mag[bsc_pkg::PSC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dividend <= dividend;
      s1_neg      <= quo_pow2[D_W-1];
      s1_index    <= osr_index;

      s2_quo      <= prod[PROD_W-1 -: DIV_W];
      s2_dividend <= s1_dividend;
      s2_neg      <= s1_neg;
      s2_index    <= s1_index;

      s3_quo      <= s2_quo;
      s3_bump     <= rem >= (DIV_W+1)'(odd3);
      s3_neg      <= s2_neg;

      scaled      <= s3_neg ? -$signed(mag_lo) : $signed(mag_lo);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsc_qmul.sv
// Three-stage Q.16 multiply-add: addend + round(a * b / 2^16), b split into a high and a low part.
`default_nettype none

module bsc_qmul #(
  parameter int A_W   = bsc_pkg::PSC_W,
  parameter int B_W   = bsc_pkg::INNER1_W,
  parameter int LO_W  = bsc_pkg::LO1_W,
  parameter int ADD_W = bsc_pkg::COEF_M_W + bsc_pkg::WORK_FRAC,
  parameter int OUT_W = bsc_pkg::INNER2_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  input  logic signed [ADD_W-1:0]  addend,
  output logic signed [OUT_W-1:0]  result
);

  localparam int HI_W   = B_W - LO_W;
  localparam int PH_W   = A_W + HI_W;
  localparam int PL_W   = A_W + LO_W + 1;
  localparam int FULL_W = A_W + B_W + 1;
  localparam int SH_W   = FULL_W - bsc_pkg::WORK_FRAC;
  localparam int SUM_W  = ((ADD_W > SH_W) ? ADD_W : SH_W) + 1;
  localparam logic signed [FULL_W-1:0] HALF = FULL_W'(1) << (bsc_pkg::WORK_FRAC - 1);

  logic signed [PH_W-1:0]   part_hi;
  logic signed [PL_W-1:0]   part_lo;
  logic signed [ADD_W-1:0]  add1;
  logic signed [FULL_W-1:0] full;
  logic signed [SH_W-1:0]   shifted;
  logic signed [ADD_W-1:0]  add2;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    full = (FULL_W'(part_hi) <<< LO_W) + FULL_W'(part_lo) + HALF;
    sum  = SUM_W'(add2) + SUM_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_hi <= a * $signed(b[B_W-1:LO_W]);
      part_lo <= a * $signed({1'b0, b[LO_W-1:0]});
      add1    <= addend;

      shifted <= SH_W'(full >>> bsc_pkg::WORK_FRAC);
      add2    <= add1;

      result  <= OUT_W'(sum);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bsc_checker.sv
// Port-level checker of the compensation block, bound to its top level.
`default_nettype none

`include "baro_sensor_compensation_macros.svh"

module bsc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic signed [bsc_pkg::OUT_W-1:0]  pressure_comp,
  input logic signed [bsc_pkg::OUT_W-1:0]  temperature_comp,
  input logic                              saturated
);

  localparam logic signed [bsc_pkg::OUT_W-1:0] MAXV = {1'b0, {(bsc_pkg::OUT_W-1){1'b1}}};
  localparam logic signed [bsc_pkg::OUT_W-1:0] MINV = {1'b1, {(bsc_pkg::OUT_W-1){1'b0}}};

  // reset empties the output register
  `BSC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result_valid after reset")

  // a held item keeps its value
  `BSC_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(pressure_comp) && $stable(temperature_comp) && $stable(saturated), "held result changed")

  // the input side stalls only behind a held result
  `BSC_ASSERT(a_stall_cause, sample_stall |-> result_valid && result_stall, "stall without held result")

  // a clip flag needs a value at a rail
  `BSC_ASSERT(a_sat_rail, result_valid && saturated |-> pressure_comp == MAXV || pressure_comp == MINV || temperature_comp == MAXV || temperature_comp == MINV, "saturated without rail value")

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);

`default_nettype wire

// File: tb/baro_sensor_compensation_test.sv
// Self-checking testbench for the pressure and temperature compensation pipeline.
module baro_sensor_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int  ITEMS_PER_PHASE = 56;
  localparam int  RAND_PHASES     = 8;
  localparam int  QUIET_LIMIT     = 400;  // cycles with no handshake at all
  localparam int  TAIL_CYCLES     = 20;   // pipeline is 13 deep
  localparam longint ONE_Q16      = longint'(1) << WORK_FRAC;

  typedef struct packed {
    logic signed [OUT_W-1:0] pressure_comp;
    logic signed [OUT_W-1:0] temperature_comp;
    logic                    saturated;
  } comp_result_t;

  // One full register set; 64-bit fields so that wide writes reach every register.
  typedef struct {
    logic [CFG_DATA_W-1:0] cal_low;
    logic [CFG_DATA_W-1:0] cal_mid;
    logic [CFG_DATA_W-1:0] cal_high;
    logic [CFG_DATA_W-1:0] p_osr;
    logic [CFG_DATA_W-1:0] t_osr;
  } cal_setting_t;

  // Directed row: which register set to run under, the reading pair, and a typed
  // result where it is obvious (known = 1); otherwise the predictor supplies it.
  typedef struct {
    int               setting;
    logic [RAW_W-1:0] p_raw;
    logic [RAW_W-1:0] t_raw;
    bit               known;
    comp_result_t     typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   sample_valid    = 1'b0;
  logic                   sample_stall;
  logic [RAW_W-1:0]       pressure_raw    = '0;
  logic [RAW_W-1:0]       temperature_raw = '0;
  logic                   result_valid;
  logic                   result_stall    = 1'b0;
  logic signed [OUT_W-1:0] pressure_comp;
  logic signed [OUT_W-1:0] temperature_comp;
  logic                   saturated;
  logic                   cfg_valid       = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data        = '0;

  // Predictor's copy of the registers, reset values.
  logic [CFG_DATA_W-1:0] cal_low  = '0;
  logic [CFG_DATA_W-1:0] cal_mid  = '0;
  logic [CAL_HIGH_W-1:0] cal_high = '0;
  logic [OSR_W-1:0]      p_osr    = OSR_RESET;
  logic [OSR_W-1:0]      t_osr    = OSR_RESET;

  comp_result_t pending_results[$];
  int           errors     = 0;
  bit           idle_on    = 1'b1;
  int           stall_left = 0;
  int           quiet      = 0;

  cal_setting_t settings [4];
  dir_row_t     dir_rows [18];

  baro_sensor_compensation DUT (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .pressure_raw     (pressure_raw),
    .temperature_raw  (temperature_raw),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .pressure_comp    (pressure_comp),
    .temperature_comp (temperature_comp),
    .saturated        (saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor, all in Q.16 on 64-bit signed values.
  // ---------------------------------------------------------------------------

  // Oversampling scale factor k for each index.
  function automatic longint osr_factor(input logic [OSR_W-1:0] idx);
    case (idx)
      3'd0: return 524288;
      3'd1: return 1572864;
      3'd2: return 3670016;
      3'd3: return 7864320;
      3'd4: return 253952;
      3'd5: return 516096;
      3'd6: return 1040384;
      default: return 2088960;
    endcase
  endfunction

  // Round half up, then floor shift (>>> on a signed value is a floor).
  function automatic longint round_q(input longint x, input int s);
    longint half;
    if (s == 0) return x;
    half = longint'(1) << (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic longint mul_q16(input longint a, input longint b);
    return round_q(a * b, WORK_FRAC);
  endfunction

  // round(raw * 2^16 / k), ties toward plus infinity
  function automatic longint scale_q16(input longint raw, input longint k);
    longint n;
    n = raw * 65536 + k / 2;
    if (n >= 0) return n / k;
    return -((-n + k - 1) / k);
  endfunction

  // Q.16 down to output fraction bits, then clip to 32 bits.
  function automatic logic signed [OUT_W-1:0] to_q_out(input longint q16, inout bit clip);
    longint v;
    v = round_q(q16, WORK_FRAC - OUT_FRAC_BITS_DEF);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      v = 32'sh7FFF_FFFF;
      clip = 1'b1;
    end else if (v < -longint'(64'sh8000_0000)) begin
      v = -longint'(64'sh8000_0000);
      clip = 1'b1;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic comp_result_t compensate(input logic [RAW_W-1:0] p_raw,
                                              input logic [RAW_W-1:0] t_raw);
    logic [143:0] cal;
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint psc, tsc, inner, pq, cross_term, tq;
    bit clip;
    comp_result_t r;
    // byte 0 lands in the top bits, byte 17 in the bottom
    cal = {cal_low, cal_mid, cal_high};
    c0  = $signed(cal[143:132]);
    c1  = $signed(cal[131:120]);
    c00 = $signed(cal[119:100]);
    c10 = $signed(cal[99:80]);
    c01 = $signed(cal[79:64]);
    c11 = $signed(cal[63:48]);
    c20 = $signed(cal[47:32]);
    c21 = $signed(cal[31:16]);
    c30 = $signed(cal[15:0]);
    psc = scale_q16(longint'($signed(p_raw)), osr_factor(p_osr));
    tsc = scale_q16(longint'($signed(t_raw)), osr_factor(t_osr));
    // Horner form of the pressure polynomial plus the temperature terms
    inner = c20 * ONE_Q16 + psc * c30;
    inner = c10 * ONE_Q16 + mul_q16(psc, inner);
    pq = c00 * ONE_Q16 + mul_q16(psc, inner);
    pq += tsc * c01;
    cross_term = c11 * ONE_Q16 + psc * c21;
    pq += mul_q16(tsc, mul_q16(psc, cross_term));
    tq = c0 * (ONE_Q16 / 2) + c1 * tsc;
    clip = 1'b0;
    r.pressure_comp    = to_q_out(pq, clip);
    r.temperature_comp = to_q_out(tq, clip);
    r.saturated        = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // One register write; leaves cfg_valid high so a burst of writes stays clean.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CALIB_LOW:  cal_low  = data;
      REG_CALIB_MID:  cal_mid  = data;
      REG_CALIB_HIGH: cal_high = data[CAL_HIGH_W-1:0];
      REG_P_OSR:      p_osr    = data[OSR_W-1:0];
      REG_T_OSR:      t_osr    = data[OSR_W-1:0];
      default: ;  // unused index, the block drops it
    endcase
    @(negedge clk);
  endtask

  // Whole register set, then junk to every unused index, which must not land.
  task automatic apply_config(input cal_setting_t s);
    write_reg(REG_CALIB_LOW,  s.cal_low);
    write_reg(REG_CALIB_MID,  s.cal_mid);
    write_reg(REG_CALIB_HIGH, s.cal_high);
    write_reg(REG_P_OSR,      s.p_osr);
    write_reg(REG_T_OSR,      s.t_osr);
    for (int i = REG_T_OSR + 1; i < (1 << CFG_INDEX_W); i++)
      write_reg(CFG_INDEX_W'(i), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Offer one reading pair, maybe after an idle burst; record its result once taken.
  task automatic send_sample(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw,
                             input bit known, input comp_result_t typed);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid    <= 1'b1;
    pressure_raw    <= p_raw;
    temperature_raw <= t_raw;
    do @(posedge clk); while (sample_stall);
    pending_results.push_back(known ? typed : compensate(p_raw, t_raw));
    @(negedge clk);
  endtask

  // Stop sending and let the pipeline empty; always advances at least one step.
  task automatic wait_all_results();
    sample_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 4))
           0: return 24'h000000;
           1: return 24'h7FFFFF;
           2: return 24'h800000;
           3: return 24'hFFFFFF;
           default: return 24'h000001;
         endcase
      1: return RAW_W'($urandom_range(0, 2000) - 1000);  // near zero, both signs
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cal();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, off in phase 2 and in the last two phases.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare every taken result with the oldest pending prediction.
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending item: pressure_comp %0d temperature_comp %0d",
               pressure_comp, temperature_comp);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (pressure_comp !== want.pressure_comp) begin
          $error("pressure_comp: expected %0d, got %0d", want.pressure_comp, pressure_comp);
          errors++;
        end
        if (temperature_comp !== want.temperature_comp) begin
          $error("temperature_comp: expected %0d, got %0d",
                 want.temperature_comp, temperature_comp);
          errors++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet > QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    cal_setting_t s;
    int cur_setting;

    // Setting 0 is the reset state and is never written.
    settings[0] = '{'0, '0, '0, 64'd1, 64'd1};
    // every coefficient at its positive maximum
    settings[1] = '{64'h7FF7_FF7F_FFF7_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF, 64'd4, 64'd4};
    // every coefficient at its negative minimum
    settings[2] = '{64'h8008_0080_0008_0000, 64'h8000_8000_8000_8000, 64'h8000, 64'd4, 64'd7};
    // all coefficients -1; wide writes whose upper bits must be dropped
    settings[3] = '{'1, '1, '1, 64'hFFFF_FFFF_FFFF_FFF8, '1};

    dir_rows = '{
      // reset calibration is all zero, so every result is zero
      '{0, 24'h000000, 24'h000000, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      '{0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      '{0, 24'h800000, 24'h800000, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      '{0, 24'hFFFFFF, 24'h000001, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      '{0, 24'h555555, 24'hAAAAAA, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
      // zero readings give c00 and c0/2 alone
      '{1, 24'h000000, 24'h000000, 1'b1, '{32'sh07FF_FF00, 32'sh0003_FF80, 1'b0}},
      // largest positive pressure clips high
      '{1, 24'h7FFFFF, 24'h000000, 1'b1, '{32'sh7FFF_FFFF, 32'sh0003_FF80, 1'b1}},
      '{1, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0},
      '{1, 24'h800000, 24'h800000, 1'b0, '0},
      '{1, 24'h800000, 24'h7FFFFF, 1'b0, '0},
      '{2, 24'h000000, 24'h000000, 1'b1, '{32'shF800_0000, 32'shFFFC_0000, 1'b0}},
      // same reading with negative coefficients clips low
      '{2, 24'h7FFFFF, 24'h000000, 1'b1, '{32'sh8000_0000, 32'shFFFC_0000, 1'b1}},
      '{2, 24'h800000, 24'h800000, 1'b0, '0},
      '{2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{3, 24'h000000, 24'h000000, 1'b1, '{32'shFFFF_FF00, 32'shFFFF_FF80, 1'b0}},
      '{3, 24'h7FFFFF, 24'h800000, 1'b0, '0},
      '{3, 24'h800000, 24'h7FFFFF, 1'b0, '0},
      '{3, 24'h000001, 24'hFFFFFF, 1'b0, '0}
    };

    // hold synchronous reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: registers change only with the pipeline empty.
    cur_setting = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur_setting) begin
        wait_all_results();
        apply_config(settings[dir_rows[i].setting]);
        cur_setting = dir_rows[i].setting;
      end
      send_sample(dir_rows[i].p_raw, dir_rows[i].t_raw, dir_rows[i].known, dir_rows[i].typed);
    end

    // Random part: a fresh register set per phase; OSR index sweeps every value.
    // Phase 2 and the last two phases run with no idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_all_results();
      idle_on = (ph < RAND_PHASES - 2) && (ph != 2);
      s.cal_low  = pick_cal();
      s.cal_mid  = pick_cal();
      s.cal_high = pick_cal();
      s.p_osr    = {$urandom, $urandom};
      s.t_osr    = {$urandom, $urandom};
      s.p_osr[OSR_W-1:0] = OSR_W'(ph);
      s.t_osr[OSR_W-1:0] = OSR_W'(RAND_PHASES - 1 - ph);
      apply_config(s);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off once mid-phase until the pipeline has emptied
        if (ph == 3 && n == ITEMS_PER_PHASE / 2)
          wait_all_results();
        send_sample(pick_raw(), pick_raw(), 1'b0, '0);
      end
    end

    // drain, then keep watching for stray results
    wait_all_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
